@@ design/mlp_pkg.sv @@
// ----------------------------------------------------------------------------
// mlp_pkg: shared constants and weight tables
// Fixed-point weights (Q7.10) and widths for the touch classifier.
// ----------------------------------------------------------------------------
package mlp_pkg;

	localparam int NUM_INPUTS_DEF  = 3;
	localparam int NUM_HIDDEN_DEF  = 5;
	localparam int NUM_CLASSES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 10;

	localparam int FEAT_W   = 16;
	localparam int FIELD_CNT = 3;
	localparam int WFRAC    = 10;
	localparam int COEF_W   = 18;
	// hidden value after ReLU and rounding fits well within this
	localparam int HID_W    = 28;
	localparam int ACC_W    = 56;
	localparam int SCORE_W  = 24;

	function automatic logic signed [COEF_W-1:0] w1(input int j, input int k);
		logic signed [COEF_W-1:0] r;
		r = '0;
		case (j)
			0: case (k)
				0: r = -18'sd7688;  1: r = -18'sd638;  2: r = 18'sd7852;
				3: r = -18'sd23;    4: r = -18'sd10668; default: r = '0;
			endcase
			1: case (k)
				0: r = -18'sd7965;  1: r = -18'sd106;  2: r = -18'sd10007;
				3: r = -18'sd111;   4: r = 18'sd8688;  default: r = '0;
			endcase
			2: case (k)
				0: r = 18'sd7013;   1: r = -18'sd140;  2: r = 18'sd9959;
				3: r = -18'sd112;   4: r = 18'sd7780;  default: r = '0;
			endcase
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [COEF_W-1:0] b1(input int k);
		logic signed [COEF_W-1:0] r;
		r = '0;
		case (k)
			0: r = 18'sd6089; 2: r = -18'sd655; 4: r = 18'sd1033;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [COEF_W-1:0] w2(input int j, input int k);
		logic signed [COEF_W-1:0] r;
		r = '0;
		case (j)
			0: case (k)
				0: r = 18'sd3459;   1: r = -18'sd15733; 2: r = 18'sd6854;
				3: r = -18'sd19060; 4: r = 18'sd7581;   5: r = -18'sd760;
				6: r = -18'sd11034; 7: r = -18'sd2186;  default: r = '0;
			endcase
			1: case (k)
				0: r = 18'sd128;  1: r = -18'sd69;  2: r = -18'sd290;
				3: r = -18'sd374; 4: r = 18'sd96;   5: r = 18'sd477;
				6: r = 18'sd238;  7: r = 18'sd483;  default: r = '0;
			endcase
			2: case (k)
				0: r = -18'sd11385; 1: r = 18'sd6129;  2: r = -18'sd7736;
				3: r = 18'sd6594;   4: r = -18'sd8593; 5: r = 18'sd2370;
				6: r = -18'sd17822; 7: r = 18'sd1089;  default: r = '0;
			endcase
			3: case (k)
				0: r = -18'sd652; 1: r = 18'sd553;  2: r = -18'sd377;
				3: r = -18'sd622; 4: r = 18'sd614;  5: r = -18'sd250;
				6: r = 18'sd303;  7: r = 18'sd126;  default: r = '0;
			endcase
			4: case (k)
				0: r = -18'sd3820;  1: r = 18'sd1296; 2: r = -18'sd16304;
				3: r = -18'sd6798;  4: r = -18'sd6182; 5: r = 18'sd2728;
				6: r = 18'sd4784;   7: r = 18'sd1147; default: r = '0;
			endcase
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [COEF_W-1:0] b2(input int k);
		logic signed [COEF_W-1:0] r;
		r = '0;
		case (k)
			0: r = 18'sd11943;  1: r = -18'sd3331;  2: r = -18'sd1499;
			3: r = 18'sd1484;   4: r = -18'sd10888; 5: r = -18'sd15888;
			6: r = -18'sd6194;  7: r = 18'sd14524;  default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ design/mlp_hidden_lane.sv @@
// ----------------------------------------------------------------------------
// mlp_hidden_lane: one hidden neuron
// Registered products, then sum, ReLU and rounding to a hidden value.
// ----------------------------------------------------------------------------
module mlp_hidden_lane #(
	parameter int LANE       = 0,
	parameter int NUM_INPUTS = mlp_pkg::NUM_INPUTS_DEF,
	parameter int FRAC_BITS  = mlp_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en_s1,
	input  logic                                en_s2,
	input  logic signed [mlp_pkg::FEAT_W-1:0]   feat [NUM_INPUTS],
	output logic signed [mlp_pkg::HID_W-1:0]    hid_s2
);

	logic signed [mlp_pkg::ACC_W-1:0] prod_s1 [NUM_INPUTS];
	logic signed [mlp_pkg::ACC_W-1:0] acc;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int j = 0; j < NUM_INPUTS; j++) begin
				prod_s1[j] <= mlp_pkg::ACC_W'(feat[j] * mlp_pkg::w1(j, LANE));
			end
		end
	end

	always_comb begin
		acc = mlp_pkg::ACC_W'(mlp_pkg::b1(LANE)) <<< FRAC_BITS;
		for (int j = 0; j < NUM_INPUTS; j++) begin
			acc = acc + prod_s1[j];
		end
		if (acc < 0) begin
			acc = '0;
		end
		acc = (acc + mlp_pkg::ACC_W'(1 << (mlp_pkg::WFRAC - 1))) >>> mlp_pkg::WFRAC;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			hid_s2 <= mlp_pkg::HID_W'(acc);
		end
	end

endmodule

@@ design/mlp_score_lane.sv @@
// ----------------------------------------------------------------------------
// mlp_score_lane: one output class score
// Registered products of hidden values, then sum and rounding.
// ----------------------------------------------------------------------------
module mlp_score_lane #(
	parameter int LANE       = 0,
	parameter int NUM_HIDDEN = mlp_pkg::NUM_HIDDEN_DEF,
	parameter int FRAC_BITS  = mlp_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               en_s3,
	input  logic                               en_s4,
	input  logic signed [mlp_pkg::HID_W-1:0]   hid [NUM_HIDDEN],
	output logic signed [mlp_pkg::ACC_W-1:0]   score_s4
);

	logic signed [mlp_pkg::ACC_W-1:0] prod_s3 [NUM_HIDDEN];
	logic signed [mlp_pkg::ACC_W-1:0] acc;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int j = 0; j < NUM_HIDDEN; j++) begin
				prod_s3[j] <= mlp_pkg::ACC_W'(hid[j] * mlp_pkg::w2(j, LANE));
			end
		end
	end

	always_comb begin
		acc = mlp_pkg::ACC_W'(mlp_pkg::b2(LANE)) <<< FRAC_BITS;
		for (int j = 0; j < NUM_HIDDEN; j++) begin
			acc = acc + prod_s3[j];
		end
		acc = (acc + mlp_pkg::ACC_W'(1 << (mlp_pkg::WFRAC - 1))) >>> mlp_pkg::WFRAC;
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			score_s4 <= acc;
		end
	end

endmodule

@@ design/mlp_argmax.sv @@
// ----------------------------------------------------------------------------
// mlp_argmax: merge of the class lanes
// Strict-greater scan picks the lowest index on ties; saturates the winner.
// ----------------------------------------------------------------------------
module mlp_argmax #(
	parameter int NUM_CLASSES = mlp_pkg::NUM_CLASSES_DEF
) (
	input  logic signed [mlp_pkg::ACC_W-1:0]    score [NUM_CLASSES],
	output logic [2:0]                          best_idx,
	output logic signed [mlp_pkg::SCORE_W-1:0]  best_sat
);

	localparam logic signed [mlp_pkg::ACC_W-1:0] SMAX =
		mlp_pkg::ACC_W'((1 <<< (mlp_pkg::SCORE_W - 1)) - 1);
	localparam logic signed [mlp_pkg::ACC_W-1:0] SMIN =
		mlp_pkg::ACC_W'(-(1 <<< (mlp_pkg::SCORE_W - 1)));

	logic signed [mlp_pkg::ACC_W-1:0] best;

	always_comb begin
		best     = score[0];
		best_idx = '0;
		for (int k = 1; k < NUM_CLASSES; k++) begin
			if (score[k] > best) begin
				best     = score[k];
				best_idx = 3'(k);
			end
		end
		if (best > SMAX) begin
			best_sat = mlp_pkg::SCORE_W'(SMAX);
		end else if (best < SMIN) begin
			best_sat = mlp_pkg::SCORE_W'(SMIN);
		end else begin
			best_sat = mlp_pkg::SCORE_W'(best);
		end
	end

endmodule

@@ design/mlp_touch_classifier_top.sv @@
// ----------------------------------------------------------------------------
// mlp_touch_classifier_top: 3-5-8 perceptron touch classifier
// Hidden lanes and class lanes in parallel, argmax merge, output register.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall  | feature_a, feature_b, feature_c
//  out     | out of    | out_valid/out_stall| class_index, top_score
//
// One word per cycle while the output is not stalled; a word passes the stages below in order to out_valid.
// Stages: layer-1 products, hidden sum, layer-2 products, score sum, merge.
// A stall on the output holds every full stage; empty stages still fill, and in_stall follows it when all are full.
// Reset clears only the stage valid bits.
module mlp_touch_classifier_top #(
	parameter int NUM_INPUTS  = mlp_pkg::NUM_INPUTS_DEF,
	parameter int NUM_HIDDEN  = mlp_pkg::NUM_HIDDEN_DEF,
	parameter int NUM_CLASSES = mlp_pkg::NUM_CLASSES_DEF,
	parameter int FRAC_BITS   = mlp_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [mlp_pkg::FEAT_W-1:0]   feature_a,
	input  logic signed [mlp_pkg::FEAT_W-1:0]   feature_b,
	input  logic signed [mlp_pkg::FEAT_W-1:0]   feature_c,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          class_index,
	output logic signed [mlp_pkg::SCORE_W-1:0]  top_score
);

	logic                              v_s1, v_s2, v_s3, v_s4;
	logic                              en1, en2, en3, en4, en5;
	logic signed [mlp_pkg::FEAT_W-1:0] feat [NUM_INPUTS];
	logic signed [mlp_pkg::HID_W-1:0]  hid_s2 [NUM_HIDDEN];
	logic signed [mlp_pkg::ACC_W-1:0]  score_s4 [NUM_CLASSES];
	logic [2:0]                        best_idx;
	logic signed [mlp_pkg::SCORE_W-1:0] best_sat;

	always_comb begin
		for (int j = 0; j < NUM_INPUTS; j++) begin
			feat[j] = '0;
		end
		feat[0] = feature_a;
		if (NUM_INPUTS > 1) feat[1 % NUM_INPUTS] = feature_b;
		if (NUM_INPUTS > 2) feat[2 % NUM_INPUTS] = feature_c;
	end

	// advance a stage when its successor is free or moving
	assign en5 = !out_valid || !out_stall;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) out_valid <= v_s4;
		end
	end

	for (genvar k = 0; k < NUM_HIDDEN; k++) begin : g_hid
		mlp_hidden_lane #(.LANE(k), .NUM_INPUTS(NUM_INPUTS), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk), .en_s1(en1), .en_s2(en2), .feat(feat), .hid_s2(hid_s2[k])
		);
	end

	for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_cls
		mlp_score_lane #(.LANE(k), .NUM_HIDDEN(NUM_HIDDEN), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk(clk), .en_s3(en3), .en_s4(en4), .hid(hid_s2), .score_s4(score_s4[k])
		);
	end

	mlp_argmax #(.NUM_CLASSES(NUM_CLASSES)) u_argmax (
		.score(score_s4), .best_idx(best_idx), .best_sat(best_sat)
	);

	always_ff @(posedge clk) begin
		if (en5) begin
			class_index <= best_idx;
			top_score   <= best_sat;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(class_index) && $stable(top_score))
		else $error("result changed under stall");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall && v_s4 |=> out_valid)
		else $error("stage four word lost");

endmodule
